// ===== rtl/bda_pkg.sv =====
`default_nettype none

package bda_pkg;

  localparam int PIX_W = 8;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_MAX_BLOCK  = 16;

  localparam int RESET_WIDTH  = 4096;
  localparam int RESET_HEIGHT = 4096;
  localparam int RESET_BLOCK  = 4;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int BLOCK_REG_W = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SIZE    = 2'd2;

  localparam int OUT_FIFO_DEPTH = 8;

  typedef logic [PIX_W-1:0] chan_t;

  typedef struct packed {
    logic frame_end;
    logic row_end;
  } flags_t;

  typedef struct packed {
    flags_t flags;
    chan_t  blue;
    chan_t  green;
    chan_t  red;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/bda_ram.sv =====
`default_nettype none

module bda_ram #(
  parameter int DATA_W = 48,
  parameter int DEPTH  = 4096
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [DATA_W-1:0]        wdata,
  input  wire                     re,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]       rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/box_downsample_average.sv =====
// path: a block average is valid on out_ once stage 1, stages 2 and 3 and the result queue
//   have registered the transaction that carries the block's bottom-right pixel
// throughput: one pixel per cycle, set by the single line-store read-modify-write per
//   block and row with write forwarding; input stalls only while 8 results are outstanding
// reset: counters to the frame origin, size registers to their reset values; the line
//   store is not cleared, as each entry is written by the first row of its band
`default_nettype none

module box_downsample_average #(
  parameter int MAX_WIDTH  = bda_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bda_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_BLOCK  = bda_pkg::DEF_MAX_BLOCK
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // configuration
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [bda_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire [bda_pkg::CFG_DATA_W-1:0]     cfg_data,
  // source pixels
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire [3*bda_pkg::PIX_W-1:0]        in_tdata,   // in_red, in_green, in_blue
  // block averages
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [3*bda_pkg::PIX_W-1:0]       out_tdata,  // out_red, out_green, out_blue
  output logic                              out_tlast,  // row_end
  output logic [0:0]                        out_tuser   // frame_end
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW     = CW + 1;
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int HW     = RW + 1;
  localparam int BW     = $clog2(MAX_BLOCK);
  localparam int LW     = BW + 1;
  localparam int HS_W   = $clog2(MAX_BLOCK * 255 + 1);
  localparam int SUM_W  = $clog2(MAX_BLOCK * MAX_BLOCK * 255 + 1);
  localparam int AREA_W = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
  localparam int SH     = SUM_W + AREA_W;
  localparam int M_W    = SH + 1;
  localparam int P_W    = SUM_W + M_W;
  localparam int TAB_N  = MAX_BLOCK + 1;
  localparam int TAB_W  = $clog2(TAB_N);
  localparam int CMP_W  = ((WW > HW) ? WW : HW) + LW + 1;
  localparam int DEPTH  = bda_pkg::OUT_FIFO_DEPTH;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CRW    = $clog2(DEPTH + 1);
  localparam int PW     = bda_pkg::PIX_W;

  localparam int RST_W = (bda_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : bda_pkg::RESET_WIDTH;
  localparam int RST_H = (bda_pkg::RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT
                                                              : bda_pkg::RESET_HEIGHT;
  localparam int RST_L = (bda_pkg::RESET_BLOCK > MAX_BLOCK) ? MAX_BLOCK : bda_pkg::RESET_BLOCK;

  // reciprocal table: ceil(2^SH / l^2), exact for every block sum
  logic [M_W-1:0] recip_tab [TAB_N];
  assign recip_tab[0] = '0;
  for (genvar gi = 1; gi < TAB_N; gi++) begin : g_recip
    localparam longint unsigned AREA  = longint'(gi) * longint'(gi);
    localparam longint unsigned RECIP = ((64'd1 << SH) + AREA - 64'd1) / AREA;
    assign recip_tab[gi] = M_W'(RECIP);
  end

  // configuration
  logic [WW-1:0]  w_r, w_nxt;
  logic [HW-1:0]  h_r, h_nxt;
  logic [LW-1:0]  l_r, l_nxt;
  logic [M_W-1:0] recip_r, recip_nxt;
  logic           cfg_hit;
  logic [bda_pkg::BLOCK_REG_W-1:0] blk_raw;

  assign cfg_ready = 1'b1;
  assign blk_raw   = cfg_data[bda_pkg::BLOCK_REG_W-1:0];

  always_comb begin
    w_nxt     = w_r;
    h_nxt     = h_r;
    l_nxt     = l_r;
    recip_nxt = recip_r;
    cfg_hit   = 1'b0;
    if (cfg_valid) begin
      case (cfg_index)
        bda_pkg::REG_SOURCE_WIDTH: begin
          cfg_hit = 1'b1;
          if (cfg_data == '0) w_nxt = WW'(1);
          else if (32'(cfg_data) > MAX_WIDTH) w_nxt = WW'(MAX_WIDTH);
          else w_nxt = WW'(cfg_data);
        end
        bda_pkg::REG_SOURCE_HEIGHT: begin
          cfg_hit = 1'b1;
          if (cfg_data == '0) h_nxt = HW'(1);
          else if (32'(cfg_data) > MAX_HEIGHT) h_nxt = HW'(MAX_HEIGHT);
          else h_nxt = HW'(cfg_data);
        end
        bda_pkg::REG_BLOCK_SIZE: begin
          cfg_hit = 1'b1;
          if (blk_raw == '0) l_nxt = LW'(1);
          else if (32'(blk_raw) > MAX_BLOCK) l_nxt = LW'(MAX_BLOCK);
          else l_nxt = LW'(blk_raw);
          recip_nxt = recip_tab[TAB_W'(l_nxt)];
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r     <= WW'(RST_W);
      h_r     <= HW'(RST_H);
      l_r     <= LW'(RST_L);
      recip_r <= recip_tab[TAB_W'(RST_L)];
    end else begin
      w_r     <= w_nxt;
      h_r     <= h_nxt;
      l_r     <= l_nxt;
      recip_r <= recip_nxt;
    end
  end

  // raster position
  logic [CW-1:0]   col_r, col_nxt;
  logic [BW-1:0]   cph_r, cph_nxt;
  logic [WW-1:0]   col_rem_r, col_rem_nxt;
  logic [CW-1:0]   bcol_r, bcol_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [BW-1:0]   rph_r, rph_nxt;
  logic [HW-1:0]   row_rem_r, row_rem_nxt;
  logic [HS_W-1:0] hsum_r [3];
  logic [HS_W-1:0] hsum_nxt [3];
  logic [PW-1:0]   pix [3];

  logic col_ok, row_ok, blk_col_last, blk_row_last, line_last, frame_last;
  logic emit_now, wr_now, accept, rend_now, fend_now;

  assign pix[0] = in_tdata[0*PW +: PW];
  assign pix[1] = in_tdata[1*PW +: PW];
  assign pix[2] = in_tdata[2*PW +: PW];

  assign col_ok       = CMP_W'(col_rem_r) >= CMP_W'(l_r);
  assign row_ok       = CMP_W'(row_rem_r) >= CMP_W'(l_r);
  assign blk_col_last = LW'(cph_r) == l_r - LW'(1);
  assign blk_row_last = LW'(rph_r) == l_r - LW'(1);
  assign line_last    = WW'(col_r) == w_r - WW'(1);
  assign frame_last   = HW'(row_r) == h_r - HW'(1);
  assign rend_now     = CMP_W'(col_rem_r) < CMP_W'({l_r, 1'b0});
  assign fend_now     = rend_now && (CMP_W'(row_rem_r) < CMP_W'({l_r, 1'b0}));
  assign emit_now     = col_ok && row_ok && blk_col_last && blk_row_last;

  // result credits: results accepted on input but not yet taken on output
  logic [CRW-1:0] cred_r, cred_nxt;
  logic           out_pop;

  assign in_tready = !(emit_now && (cred_r == CRW'(DEPTH)));
  assign accept    = in_tvalid && in_tready;
  assign wr_now    = accept && col_ok && row_ok && blk_col_last;
  assign out_pop   = out_tvalid && out_tready;

  always_comb begin
    cred_nxt = cred_r;
    if (accept && emit_now && !out_pop) cred_nxt = cred_r + CRW'(1);
    else if (!(accept && emit_now) && out_pop) cred_nxt = cred_r - CRW'(1);
  end

  always_comb begin
    col_nxt     = col_r;
    cph_nxt     = cph_r;
    col_rem_nxt = col_rem_r;
    bcol_nxt    = bcol_r;
    row_nxt     = row_r;
    rph_nxt     = rph_r;
    row_rem_nxt = row_rem_r;
    for (int c = 0; c < 3; c++) begin
      hsum_nxt[c] = hsum_r[c];
    end
    if (cfg_hit) begin
      col_nxt     = '0;
      cph_nxt     = '0;
      col_rem_nxt = w_nxt;
      bcol_nxt    = '0;
      row_nxt     = '0;
      rph_nxt     = '0;
      row_rem_nxt = h_nxt;
    end else if (accept) begin
      if (col_ok && row_ok) begin
        for (int c = 0; c < 3; c++) begin
          hsum_nxt[c] = (cph_r == '0) ? HS_W'(pix[c]) : hsum_r[c] + HS_W'(pix[c]);
        end
      end
      if (line_last) begin
        col_nxt     = '0;
        cph_nxt     = '0;
        col_rem_nxt = w_r;
        bcol_nxt    = '0;
        if (frame_last) begin
          row_nxt     = '0;
          rph_nxt     = '0;
          row_rem_nxt = h_r;
        end else begin
          row_nxt = row_r + RW'(1);
          if (blk_row_last) begin
            rph_nxt = '0;
            if (row_ok) row_rem_nxt = row_rem_r - HW'(l_r);
          end else begin
            rph_nxt = rph_r + BW'(1);
          end
        end
      end else begin
        col_nxt = col_r + CW'(1);
        if (blk_col_last) begin
          cph_nxt  = '0;
          bcol_nxt = bcol_r + CW'(1);
          if (col_ok) col_rem_nxt = col_rem_r - WW'(l_r);
        end else begin
          cph_nxt = cph_r + BW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      cph_r     <= '0;
      col_rem_r <= WW'(RST_W);
      bcol_r    <= '0;
      row_r     <= '0;
      rph_r     <= '0;
      row_rem_r <= HW'(RST_H);
      cred_r    <= '0;
    end else begin
      col_r     <= col_nxt;
      cph_r     <= cph_nxt;
      col_rem_r <= col_rem_nxt;
      bcol_r    <= bcol_nxt;
      row_r     <= row_nxt;
      rph_r     <= rph_nxt;
      row_rem_r <= row_rem_nxt;
      cred_r    <= cred_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      hsum_r[c] <= hsum_nxt[c];
    end
  end

  // stage 1: line store read-modify-write
  logic                s1_vld_r, s1_emit_r, s1_first_r;
  logic [CW-1:0]       s1_addr_r;
  logic [HS_W-1:0]     s1_h_r [3];
  bda_pkg::flags_t     s1_flags_r;
  logic [3*SUM_W-1:0]  ram_rdata, old_word, new_word;
  logic                wr_vld_r;
  logic [CW-1:0]       wr_addr_r;
  logic [3*SUM_W-1:0]  wr_data_r;
  logic                fwd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      wr_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= wr_now;
      wr_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_emit_r  <= emit_now;
    s1_first_r <= rph_r == '0;
    s1_addr_r  <= bcol_r;
    s1_flags_r <= '{frame_end: fend_now, row_end: rend_now};
    for (int c = 0; c < 3; c++) begin
      s1_h_r[c] <= hsum_nxt[c];
    end
    wr_addr_r <= s1_addr_r;
    wr_data_r <= new_word;
  end

  bda_ram #(
    .DATA_W (3 * SUM_W),
    .DEPTH  (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_vld_r),
    .waddr (s1_addr_r),
    .wdata (new_word),
    .re    (wr_now && (rph_r != '0)),
    .raddr (bcol_r),
    .rdata (ram_rdata)
  );

  assign fwd      = wr_vld_r && (wr_addr_r == s1_addr_r);
  assign old_word = fwd ? wr_data_r : ram_rdata;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      new_word[c*SUM_W +: SUM_W] = s1_first_r ? SUM_W'(s1_h_r[c])
                                   : old_word[c*SUM_W +: SUM_W] + SUM_W'(s1_h_r[c]);
    end
  end

  // stage 2 and 3: reciprocal multiply
  logic            s2_vld_r, s3_vld_r;
  logic [SUM_W-1:0] s2_sum_r [3];
  logic [P_W-1:0]  s3_prod_r [3];
  bda_pkg::flags_t s2_flags_r, s3_flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r && s1_emit_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_flags_r <= s1_flags_r;
    s3_flags_r <= s2_flags_r;
    for (int c = 0; c < 3; c++) begin
      s2_sum_r[c]  <= new_word[c*SUM_W +: SUM_W];
      s3_prod_r[c] <= P_W'(s2_sum_r[c]) * P_W'(recip_r);
    end
  end

  // result queue
  bda_pkg::result_t fifo_r [DEPTH];
  bda_pkg::result_t push_item, head;
  logic [PTR_W:0]   wp_r, rp_r, fifo_cnt;

  assign push_item.flags = s3_flags_r;
  assign push_item.red   = s3_prod_r[0][SH +: PW];
  assign push_item.green = s3_prod_r[1][SH +: PW];
  assign push_item.blue  = s3_prod_r[2][SH +: PW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (s3_vld_r) wp_r <= wp_r + (PTR_W+1)'(1);
      if (out_pop) rp_r <= rp_r + (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s3_vld_r) fifo_r[wp_r[PTR_W-1:0]] <= push_item;
  end

  assign fifo_cnt   = wp_r - rp_r;
  assign head       = fifo_r[rp_r[PTR_W-1:0]];
  assign out_tvalid = wp_r != rp_r;
  assign out_tdata  = {head.blue, head.green, head.red};
  assign out_tlast  = head.flags.row_end;
  assign out_tuser  = head.flags.frame_end;

  a_cred_max: assert property (@(posedge clk) disable iff (!rst_n)
    cred_r <= CRW'(DEPTH))
    else $error("result credits above queue depth");

  a_cred_cover: assert property (@(posedge clk) disable iff (!rst_n)
    CRW'(fifo_cnt) <= cred_r)
    else $error("queued results exceed credits");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r |-> (fifo_cnt != (PTR_W+1)'(DEPTH)))
    else $error("push into full result queue");

  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tlast)
    else $error("frame end without row end");

  a_emit_write: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && emit_now) |=> (s1_vld_r && s1_emit_r))
    else $error("emitting transaction lost before line store");

endmodule

`default_nettype wire
